// ===== hw/rtl/bsa_pkg.sv =====
// Package for the bitmap slot allocator: sizes, command and status codes,
// controller/datapath struct types and the lowest-set-bit helper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bsa_pkg;

    localparam int MAX_SLOTS   = 4096;
    localparam int WORD_BITS   = 64;
    localparam int STORE_WORDS = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W      = $clog2(STORE_WORDS);
    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int IDX_W       = 12;
    localparam int CNT_W       = 13;
    localparam int GRP_SIZE    = 8;
    localparam int GRP_W       = 3;
    localparam int GROUPS      = WORD_BITS / GRP_SIZE;
    localparam int APB_DW      = 32;
    localparam int PADDR_W     = 3;

    localparam logic [CNT_W-1:0] COUNT_RESET = 13'd4096;
    localparam logic [CNT_W-1:0] COUNT_MAX   = 13'd4096;

    localparam logic [1:0] CMD_USED  = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_FIND  = 2'd2;
    localparam logic [1:0] CMD_ALLOC = 2'd3;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_NONE  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic REG_SLOT_COUNT = 1'b0;

    typedef struct packed {
        logic       load;
        logic       rd_mark;
        logic       rd_first;
        logic       rd_next;
        logic       latch_mark;
        logic       latch_hit;
        logic       wr_en;
        logic       out_load;
        logic [1:0] status;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] cmd;
        logic       in_range;
        logic       cnt_zero;
        logic       hit;
        logic       last;
    } t_dp_stat;

    typedef struct packed {
        logic             hit;
        logic [BIT_W-1:0] idx;
    } t_ffs;

    // lowest set bit, two levels of eight
    function automatic t_ffs find_first(input logic [WORD_BITS-1:0] v);
        logic [GROUPS-1:0] any;
        logic [GRP_W-1:0]  sub [GROUPS];
        t_ffs              r;
        for (int g = 0; g < GROUPS; g++) begin
            any[g] = |v[g*GRP_SIZE +: GRP_SIZE];
            sub[g] = '0;
            for (int b = GRP_SIZE - 1; b >= 0; b--) begin
                if (v[g*GRP_SIZE + b]) begin
                    sub[g] = GRP_W'(b);
                end
            end
        end
        r.hit = |v;
        r.idx = '0;
        for (int g = GROUPS - 1; g >= 0; g--) begin
            if (any[g]) begin
                r.idx = {GRP_W'(g), sub[g]};
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bsa_req_if.sv =====
// Request channel of the bitmap slot allocator: valid/ready plus command.
// Depends on bsa_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bsa_req_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               command;
    logic [bsa_pkg::IDX_W-1:0] slot_index;

    modport source (output valid, output command, output slot_index, input ready);
    modport sink   (input valid, input command, input slot_index, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bsa_res_if.sv =====
// Result channel of the bitmap slot allocator: valid/ready plus status and index.
// Depends on bsa_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bsa_res_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic [bsa_pkg::IDX_W-1:0] result_index;

    modport source (output valid, output status, output result_index, input ready);
    modport sink   (input valid, input status, input result_index, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bsa_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bsa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bsa_dp.sv =====
// Datapath of the bitmap slot allocator: bitmap RAM, word valid bits, scan
// counter, hit capture and result register. Depends on bsa_pkg, bsa_ram.
`timescale 1ns / 1ps
`default_nettype none

module bsa_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [bsa_pkg::CNT_W-1:0]     i_slot_count,
    input  wire logic [1:0]                    i_command,
    input  wire logic [bsa_pkg::IDX_W-1:0]     i_slot_index,
    input  wire bsa_pkg::t_dp_cmd              i_cmd,
    output bsa_pkg::t_dp_stat                  o_stat,
    output logic      [1:0]                    o_status,
    output logic      [bsa_pkg::IDX_W-1:0]     o_result_index
);

    logic [1:0]                        r_cmd;
    logic [bsa_pkg::IDX_W-1:0]         r_idx;
    logic [bsa_pkg::ADDR_W-1:0]        r_addr;
    logic                              r_rd_vld;
    logic [bsa_pkg::STORE_WORDS-1:0]   r_vld;
    logic [bsa_pkg::WORD_BITS-1:0]     r_hit_word;
    logic [bsa_pkg::ADDR_W-1:0]        r_hit_addr;
    logic [bsa_pkg::BIT_W-1:0]         r_hit_bit;
    logic [1:0]                        r_res_status;
    logic [bsa_pkg::IDX_W-1:0]         r_res_index;

    logic [bsa_pkg::CNT_W-1:0]         n_eff;
    logic [bsa_pkg::CNT_W-1:0]         n_eff_m1;
    logic [bsa_pkg::ADDR_W-1:0]        last_word;
    logic [bsa_pkg::WORD_BITS-1:0]     part_mask;
    logic [bsa_pkg::WORD_BITS-1:0]     limit;
    logic [bsa_pkg::WORD_BITS-1:0]     ram_q;
    logic [bsa_pkg::WORD_BITS-1:0]     word;
    logic [bsa_pkg::WORD_BITS-1:0]     bit_sel;
    logic [bsa_pkg::WORD_BITS-1:0]     wr_data;
    logic                              rd_en;
    logic [bsa_pkg::ADDR_W-1:0]        rd_addr;
    bsa_pkg::t_ffs                     ffs;

    assign n_eff     = (i_slot_count > bsa_pkg::COUNT_MAX) ? bsa_pkg::COUNT_MAX : i_slot_count;
    assign n_eff_m1  = n_eff - bsa_pkg::CNT_W'(1);
    assign last_word = n_eff_m1[bsa_pkg::BIT_W +: bsa_pkg::ADDR_W];
    assign part_mask = (bsa_pkg::WORD_BITS'(1) << n_eff[bsa_pkg::BIT_W-1:0])
                       - bsa_pkg::WORD_BITS'(1);
    assign limit     = ({1'b0, r_addr} < n_eff[bsa_pkg::CNT_W-1:bsa_pkg::BIT_W])
                       ? '1 : part_mask;
    assign word      = r_rd_vld ? ram_q : '0;
    assign ffs       = bsa_pkg::find_first(~word & limit);

    assign rd_en   = i_cmd.rd_mark | i_cmd.rd_first | i_cmd.rd_next;
    always_comb begin
        priority if (i_cmd.rd_mark) begin
            rd_addr = r_idx[bsa_pkg::BIT_W +: bsa_pkg::ADDR_W];
        end else if (i_cmd.rd_first) begin
            rd_addr = '0;
        end else begin
            rd_addr = r_addr + bsa_pkg::ADDR_W'(1);
        end
    end

    assign bit_sel = bsa_pkg::WORD_BITS'(1) << r_hit_bit;
    assign wr_data = (r_cmd == bsa_pkg::CMD_FREE) ? (r_hit_word & ~bit_sel)
                                                  : (r_hit_word | bit_sel);

    bsa_ram #(
        .WIDTH (bsa_pkg::WORD_BITS),
        .DEPTH (bsa_pkg::STORE_WORDS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (r_hit_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
            r_addr   <= '0;
        end else begin
            if (i_cmd.wr_en) begin
                r_vld[r_hit_addr] <= 1'b1;
            end
            if (rd_en) begin
                r_rd_vld <= r_vld[rd_addr];
            end
            if (i_cmd.rd_first) begin
                r_addr <= '0;
            end else if (i_cmd.rd_next) begin
                r_addr <= r_addr + bsa_pkg::ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_command;
            r_idx <= i_slot_index;
        end
        if (i_cmd.latch_mark) begin
            r_hit_word <= word;
            r_hit_addr <= r_idx[bsa_pkg::BIT_W +: bsa_pkg::ADDR_W];
            r_hit_bit  <= r_idx[bsa_pkg::BIT_W-1:0];
        end else if (i_cmd.latch_hit) begin
            r_hit_word <= word;
            r_hit_addr <= r_addr;
            r_hit_bit  <= ffs.idx;
        end
        if (i_cmd.out_load) begin
            r_res_status <= i_cmd.status;
            r_res_index  <= (i_cmd.status == bsa_pkg::ST_DONE) ? {r_hit_addr, r_hit_bit} : '0;
        end
    end

    assign o_stat.cmd      = r_cmd;
    assign o_stat.in_range = {1'b0, r_idx} < n_eff;
    assign o_stat.cnt_zero = (n_eff == '0);
    assign o_stat.hit      = ffs.hit;
    assign o_stat.last     = (r_addr == last_word);

    assign o_status       = r_res_status;
    assign o_result_index = r_res_index;

endmodule

`default_nettype wire

// ===== hw/rtl/bsa_ctrl.sv =====
// Controller of the bitmap slot allocator: request decode, mark and scan
// sequencing, result handoff. Depends on bsa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsa_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    input  wire bsa_pkg::t_dp_stat i_stat,
    output bsa_pkg::t_dp_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEC,
        S_MWAIT,
        S_SCAN,
        S_FIN
    } t_state_e;

    t_state_e   r_state, n_state;
    logic [1:0] r_status, n_status;
    logic       r_wr_pend, n_wr_pend;
    logic       r_out_valid;
    logic       out_free;
    logic       is_mark;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign out_free    = !r_out_valid || i_out_ready;
    assign is_mark     = (i_stat.cmd == bsa_pkg::CMD_USED) || (i_stat.cmd == bsa_pkg::CMD_FREE);

    always_comb begin
        n_state   = r_state;
        n_status  = r_status;
        n_wr_pend = r_wr_pend;
        o_cmd     = '0;
        o_cmd.status = r_status;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                n_status  = bsa_pkg::ST_DONE;
                n_wr_pend = 1'b0;
                priority if (is_mark && !i_stat.in_range) begin
                    n_status = bsa_pkg::ST_RANGE;
                    n_state  = S_FIN;
                end else if (is_mark) begin
                    o_cmd.rd_mark = 1'b1;
                    n_state       = S_MWAIT;
                end else if (i_stat.cnt_zero) begin
                    n_status = bsa_pkg::ST_NONE;
                    n_state  = S_FIN;
                end else begin
                    o_cmd.rd_first = 1'b1;
                    n_state        = S_SCAN;
                end
            end
            S_MWAIT: begin
                o_cmd.latch_mark = 1'b1;
                n_wr_pend        = 1'b1;
                n_state          = S_FIN;
            end
            S_SCAN: begin
                priority if (i_stat.hit) begin
                    o_cmd.latch_hit = 1'b1;
                    n_wr_pend       = (i_stat.cmd == bsa_pkg::CMD_ALLOC);
                    n_state         = S_FIN;
                end else if (i_stat.last) begin
                    n_status = bsa_pkg::ST_NONE;
                    n_state  = S_FIN;
                end else begin
                    o_cmd.rd_next = 1'b1;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.wr_en    = r_wr_pend;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_status    <= bsa_pkg::ST_DONE;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_status  <= n_status;
            r_wr_pend <= n_wr_pend;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bitmap_slot_allocator_unit.sv =====
// Top level of the bitmap slot allocator: APB register, controller and
// datapath. Depends on bsa_pkg, bsa_req_if, bsa_res_if, bsa_ctrl, bsa_dp.
//
// Usage:
//   i_req carries one request (command, slot_index), taken on valid && ready.
//   o_res returns exactly one result (status, result_index) per request.
//   APB register 0 (byte 0) is slot_count, 13 bits, reset 4096; values above
//   4096 act as 4096. Write it only while no request is in flight.
// Steps, one request at a time, from accept to result valid:
//   mark used / mark free: decode, bitmap word read, result load with write.
//   out-of-range mark, or find/allocate with zero count: decode, result load.
//   find / allocate: decode, a scan of k words (1..64) one word per cycle from
//   the registered read port of the 64-word bitmap RAM, then result load.
// Reset clears the bitmap at once through per-word valid bits; there is no
// clearing pass. A request is accepted while a prior result still waits;
// if o_res is stalled the block holds its next result until the slot frees.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_slot_allocator_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    bsa_req_if.sink                            i_req,
    bsa_res_if.source                          o_res,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bsa_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [bsa_pkg::APB_DW-1:0]    pwdata,
    output logic      [bsa_pkg::APB_DW-1:0]    prdata,
    output logic                               pready
);

    logic [bsa_pkg::CNT_W-1:0] r_slot_count;
    logic                      reg_sel;
    bsa_pkg::t_dp_cmd          dp_cmd;
    bsa_pkg::t_dp_stat         dp_stat;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == bsa_pkg::REG_SLOT_COUNT);
    assign prdata  = reg_sel ? bsa_pkg::APB_DW'(r_slot_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= bsa_pkg::COUNT_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_slot_count <= pwdata[bsa_pkg::CNT_W-1:0];
        end
    end

    bsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    bsa_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_slot_count   (r_slot_count),
        .i_command      (i_req.command),
        .i_slot_index   (i_req.slot_index),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .o_status       (o_res.status),
        .o_result_index (o_res.result_index)
    );

    a_err_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.status != bsa_pkg::ST_DONE)) |-> (o_res.result_index == '0))
        else $error("non-done result carries a nonzero index");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.status == bsa_pkg::ST_DONE || o_res.status == bsa_pkg::ST_NONE
                         || o_res.status == bsa_pkg::ST_RANGE))
        else $error("illegal result status");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request accepted while another is in flight");

    a_write_with_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.wr_en |-> dp_cmd.out_load)
        else $error("bitmap write without result load");

endmodule

`default_nettype wire
